[hw/rtl/huffman_bit_packer_core_assert.svh]
// Assertion macros for the top-level core RTL file.
`ifndef HUFFMAN_BIT_PACKER_CORE_ASSERT_SVH
`define HUFFMAN_BIT_PACKER_CORE_ASSERT_SVH

`define HBP_ASSERT_IMPLIES(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("hbp: implication check failed");

`define HBP_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("hbp: next-cycle check failed");

`endif

[hw/rtl/hbp_pkg.sv]
`default_nettype none

package hbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 128;

    localparam int CODE_W    = 32;
    localparam int LEN_W     = 6;
    localparam int SYM_W     = 7;
    localparam int MODE_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int PAD_W     = 3;
    localparam int LEN_LIMIT = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
    localparam int ADDR_W    = $clog2(SYMBOL_COUNT);
    localparam int ENTRY_W   = LEN_W + CODE_W;
    localparam int ACC_W     = (BYTE_W - 1) + LEN_LIMIT;
    localparam int TOT_W     = $clog2(ACC_W + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW   = $clog2(FIFO_DEPTH);

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;

    typedef enum logic {
        KIND_ENCODE,
        KIND_FINISH
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [LEN_W-1:0]    len;
        logic [CODE_W-1:0]   bits;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic [PAD_W-1:0]  pad_bits;
        logic              end_of_stream;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/huffman_bit_packer_core.sv]
`default_nettype none

// Streaming Huffman encoder with a byte packer. The input side takes one word per
// cycle as long as the four-entry command queue between the table lookup and the
// packer has room: a load never enters the queue, but like any word it waits while
// a lookup result cannot enter the full queue. The packer sets the sustained rate:
// it takes an encode once no whole byte is pending; each byte this completes (at
// most four) then leaves, and a finish waits for the one output register, through
// which all words leave; while a word waits there, the packer still takes encodes
// until a byte completes. All table lengths read zero at reset; no clearing pass.
module huffman_bit_packer_core
    import hbp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // symbol [6:0], code_length [12:7], code_bits [44:13], zero fill [47:45]
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // mode [1:0]
    input  wire logic [MODE_W-1:0]    i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // out_byte [7:0], pad_bits [10:8], zero fill [15:11]
    output logic [M_TDATA_W-1:0]      o_m_axis_tdata,
    // byte_valid [0], end_of_stream [1]
    output logic [1:0]                o_m_axis_tuser,
    output logic                      o_m_axis_tlast
);

    logic    push;
    t_cmd    push_cmd;
    logic    queue_ready;
    logic    pop;
    t_cmd    head_cmd;
    logic    head_valid;
    t_result result;

    hbp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_mode       (i_s_axis_tuser),
        .i_symbol     (i_s_axis_tdata[SYM_W-1:0]),
        .i_code_length(i_s_axis_tdata[SYM_W +: LEN_W]),
        .i_code_bits  (i_s_axis_tdata[SYM_W+LEN_W +: CODE_W]),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .i_queue_ready(queue_ready)
    );

    hbp_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .o_ready(queue_ready),
        .i_pop  (pop),
        .o_cmd  (head_cmd),
        .o_valid(head_valid)
    );

    hbp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(head_valid),
        .i_cmd      (head_cmd),
        .o_pop      (pop),
        .o_valid    (o_m_axis_tvalid),
        .o_result   (result),
        .i_ready    (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {5'b0, result.pad_bits, result.out_byte};
    assign o_m_axis_tuser = {result.end_of_stream, result.byte_valid};
    assign o_m_axis_tlast = result.last;

`include "huffman_bit_packer_core_assert.svh"

    `HBP_ASSERT_IMPLIES(a_empty_word_is_eos, o_m_axis_tvalid && !o_m_axis_tuser[0], o_m_axis_tuser[1] && o_m_axis_tlast && (o_m_axis_tdata == '0))
    `HBP_ASSERT_IMPLIES(a_eos_is_last, o_m_axis_tvalid && o_m_axis_tuser[1], o_m_axis_tlast)
    `HBP_ASSERT_IMPLIES(a_pad_only_on_eos, o_m_axis_tvalid && (o_m_axis_tdata[10:8] != '0), o_m_axis_tuser[1])
    `HBP_ASSERT_NEXT(a_pop_needs_head, pop && !head_valid, 1'b0)

endmodule

`default_nettype wire

[hw/rtl/hbp_ram.sv]
`default_nettype none

module hbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/hbp_front.sv]
`default_nettype none

module hbp_front
    import hbp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [MODE_W-1:0]  i_mode,
    input  wire logic [SYM_W-1:0]   i_symbol,
    input  wire logic [LEN_W-1:0]   i_code_length,
    input  wire logic [CODE_W-1:0]  i_code_bits,
    output logic                    o_push,
    output t_cmd                    o_cmd,
    input  wire logic               i_queue_ready
);

    logic [SYMBOL_COUNT-1:0] r_present;
    logic                    r_s1_valid;
    logic                    n_s1_valid;
    t_kind                   r_s1_kind;
    logic                    r_s1_hit;
    logic [ENTRY_W-1:0]      rd_entry;
    logic [SYM_W:0]          sym_ext;
    logic [ADDR_W-1:0]       idx;
    logic                    in_range;
    logic                    accept;
    logic                    do_load;
    logic                    do_encode;
    logic                    do_finish;
    logic [LEN_W-1:0]        sat_len;
    logic [LEN_W-1:0]        s1_len;
    logic [CODE_W-1:0]       s1_mask;
    logic                    s1_free;

    assign sym_ext  = {1'b0, i_symbol};
    assign idx      = sym_ext[ADDR_W-1:0];
    assign in_range = (9'(sym_ext) < 9'(SYMBOL_COUNT));
    assign accept   = i_valid && o_ready;
    assign do_load   = accept && (i_mode == MODE_LOAD) && in_range;
    assign do_encode = accept && (i_mode == MODE_ENCODE) && in_range;
    assign do_finish = accept && (i_mode == MODE_FINISH);
    assign sat_len  = (i_code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : i_code_length;

    hbp_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SYMBOL_COUNT)
    ) u_code_ram (
        .i_clk  (i_clk),
        .i_we   (do_load),
        .i_waddr(idx),
        .i_wdata({sat_len, i_code_bits}),
        .i_re   (do_encode),
        .i_raddr(idx),
        .o_rdata(rd_entry)
    );

    // An entry never loaded since reset reads as length zero.
    assign s1_len  = (r_s1_kind == KIND_ENCODE && r_s1_hit) ?
                     rd_entry[ENTRY_W-1 -: LEN_W] : '0;
    assign s1_mask = (s1_len == LEN_W'(CODE_W)) ? '1 :
                     CODE_W'((64'(1) << s1_len) - 64'(1));

    assign o_push = r_s1_valid && ((r_s1_kind == KIND_FINISH) || (s1_len != '0));
    assign o_cmd  = '{kind: r_s1_kind, len: s1_len, bits: rd_entry[CODE_W-1:0] & s1_mask};
    assign s1_free = !r_s1_valid || !o_push || i_queue_ready;
    assign o_ready = s1_free && i_rst_n;

    always_comb begin
        if (accept) begin
            n_s1_valid = do_encode || do_finish;
        end else begin
            n_s1_valid = r_s1_valid && !s1_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            if (do_load) begin
                r_present[idx] <= (sat_len != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind <= do_finish ? KIND_FINISH : KIND_ENCODE;
            r_s1_hit  <= r_present[idx];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/hbp_fifo.sv]
`default_nettype none

module hbp_fifo
    import hbp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_ready,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_valid
);

    t_cmd                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wptr;
    logic [FIFO_AW-1:0]   r_rptr;
    logic [FIFO_AW:0]     r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_ready = (r_count != (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/hbp_back.sv]
`default_nettype none

module hbp_back
    import hbp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_pop,
    output logic      o_valid,
    output t_result   o_result,
    input  wire logic i_ready
);

    logic [ACC_W-1:0]    r_acc;
    logic [ACC_W-1:0]    n_acc;
    logic [TOT_W-1:0]    r_total;
    logic [TOT_W-1:0]    n_total;
    logic                r_out_valid;
    logic                n_out_valid;
    t_result             r_out;
    t_result             n_out;
    logic                out_free;
    logic                draining;
    logic [2:0]          pend_cnt;
    logic [BYTE_W-2:0]   pend_mask;
    logic [BYTE_W-2:0]   pend;
    logic [TOT_W-1:0]    rest;
    logic [PAD_W-1:0]    pad;

    assign out_free  = !r_out_valid || i_ready;
    assign draining  = (r_total >= TOT_W'(BYTE_W));
    assign pend_cnt  = r_total[2:0];
    assign pend_mask = (7'(1) << pend_cnt) - 7'(1);
    assign pend      = r_acc[BYTE_W-2:0] & pend_mask;
    assign rest      = r_total - TOT_W'(BYTE_W);
    assign pad       = PAD_W'(4'(BYTE_W) - 4'(pend_cnt));

    assign o_pop = !draining && i_cmd_valid && ((i_cmd.kind == KIND_ENCODE) || out_free);

    always_comb begin
        n_acc       = r_acc;
        n_total     = r_total;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        if (draining) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out       = '{out_byte: BYTE_W'(r_acc >> rest), byte_valid: 1'b1,
                                pad_bits: '0, end_of_stream: 1'b0,
                                last: (rest < TOT_W'(BYTE_W))};
                n_total     = rest;
            end
        end else if (o_pop) begin
            if (i_cmd.kind == KIND_ENCODE) begin
                n_acc   = (ACC_W'(pend) << i_cmd.len) | ACC_W'(i_cmd.bits);
                n_total = TOT_W'(pend_cnt) + TOT_W'(i_cmd.len);
            end else begin
                n_out_valid = 1'b1;
                if (pend_cnt != '0) begin
                    n_out = '{out_byte: BYTE_W'({1'b0, pend} << pad), byte_valid: 1'b1,
                              pad_bits: pad, end_of_stream: 1'b1, last: 1'b1};
                end else begin
                    n_out = '{out_byte: '0, byte_valid: 1'b0, pad_bits: '0,
                              end_of_stream: 1'b1, last: 1'b1};
                end
                n_acc   = '0;
                n_total = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

[tb/sv/tb_huffman_bit_packer_core.sv]
`timescale 1ns / 100ps

module tb_huffman_bit_packer_core;

    import hbp_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_PCT    = 18;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 30;
    localparam int LIMIT_CYCLES = 200000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic [MODE_W-1:0]    i_s_axis_tuser = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic [1:0]           o_m_axis_tuser;
    logic                 o_m_axis_tlast;

    huffman_bit_packer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predicted encoder state.
    logic [LEN_W-1:0]  code_len_tbl [SYMBOL_COUNT];
    logic [CODE_W-1:0] code_word_tbl [SYMBOL_COUNT];
    logic [6:0]        spill_bits = '0;
    logic [2:0]        spill_count = '0;
    bit                sym_loaded [SYMBOL_COUNT];
    int                loaded_syms [$];

    t_result expected_bytes [$];
    t_result want;
    int      mismatches = 0;
    int      cycle_count = 0;
    bit      tx_gaps = 1'b1;
    bit      rx_gaps = 1'b1;
    int      hold_req = 0;
    int      hold_done = 0;

    initial begin
        for (int i = 0; i < SYMBOL_COUNT; i++) begin
            code_len_tbl[i] = '0;
            code_word_tbl[i] = '0;
            sym_loaded[i] = 1'b0;
        end
    end

    task automatic encode_expected(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] sym,
                                   input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] bits);
        logic [63:0] acc;
        int unsigned total;
        int unsigned clen;
        int unsigned pad;
        t_result r;
        case (mode)
            MODE_LOAD: begin
                if (sym < SYMBOL_COUNT) begin
                    code_len_tbl[sym] = (len > LEN_LIMIT) ? LEN_W'(LEN_LIMIT) : len;
                    code_word_tbl[sym] = bits;
                    if (!sym_loaded[sym]) begin
                        sym_loaded[sym] = 1'b1;
                        loaded_syms = {loaded_syms, int'(sym)};
                    end
                end
            end
            MODE_ENCODE: begin
                clen = (sym < SYMBOL_COUNT) ? code_len_tbl[sym] : 0;
                if (clen != 0) begin
                    acc = (64'(spill_bits) << clen)
                        | (64'(code_word_tbl[sym]) & ((64'd1 << clen) - 64'd1));
                    total = spill_count + clen;
                    while (total >= BYTE_W) begin
                        r = '0;
                        r.out_byte = 8'(acc >> (total - BYTE_W));
                        r.byte_valid = 1'b1;
                        total = total - BYTE_W;
                        r.last = (total < BYTE_W);
                        expected_bytes = {expected_bytes, r};
                    end
                    spill_count = 3'(total);
                    spill_bits = 7'(acc & ((64'd1 << total) - 64'd1));
                end
            end
            MODE_FINISH: begin
                r = '0;
                r.end_of_stream = 1'b1;
                r.last = 1'b1;
                if (spill_count != 0) begin
                    pad = BYTE_W - spill_count;
                    r.out_byte = 8'(16'(spill_bits) << pad);
                    r.byte_valid = 1'b1;
                    r.pad_bits = 3'(pad);
                end
                expected_bytes = {expected_bytes, r};
                spill_bits = '0;
                spill_count = '0;
            end
            default: begin
            end
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    // with tvalid still high, so the next word can follow without a gap.
    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] sym,
                             input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] bits);
        while (tx_gaps && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {3'b000, bits, len, sym};
        i_s_axis_tuser <= mode;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        encode_expected(mode, sym, len, bits);
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (expected_bytes.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count, input bit long_codes);
        int pick;
        int lsel;
        logic [LEN_W-1:0] len;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            lsel = $urandom_range(99);
            if (lsel < 5) begin
                len = '0;
            end else if (lsel < 12) begin
                len = LEN_W'($urandom_range(63, 33));
            end else if (long_codes) begin
                len = LEN_W'($urandom_range(32, 17));
            end else begin
                len = LEN_W'($urandom_range(32, 1));
            end
            if (loaded_syms.size() == 0 || pick < 10) begin
                send_word(MODE_LOAD, SYM_W'($urandom_range(127)), len, $urandom);
            end else if (pick < 88) begin
                send_word(MODE_ENCODE,
                          SYM_W'(loaded_syms[$urandom_range(loaded_syms.size() - 1)]),
                          LEN_W'($urandom), $urandom);
            end else if (pick < 96) begin
                send_word(MODE_FINISH, SYM_W'($urandom), LEN_W'($urandom), $urandom);
            end else begin
                send_word(MODE_UNUSED, SYM_W'($urandom), LEN_W'($urandom), $urandom);
            end
        end
    endtask

    task automatic test_directed();
        send_word(MODE_FINISH, 7'd0, 6'd0, 32'h0);
        send_word(MODE_LOAD, 7'd0, 6'd1, 32'h0000_0001);
        send_word(MODE_LOAD, 7'd127, 6'd32, 32'hFFFF_FFFF);
        send_word(MODE_LOAD, 7'd5, 6'd0, 32'h1234_5678);
        send_word(MODE_LOAD, 7'd9, 6'd63, 32'hA5A5_A5A5);
        send_word(MODE_LOAD, 7'd10, 6'd33, 32'h8000_0001);
        send_word(MODE_LOAD, 7'd3, 6'd8, 32'hDEAD_BEC3);
        send_word(MODE_LOAD, 7'd64, 6'd3, 32'h0000_0005);
        send_word(MODE_ENCODE, 7'd0, 6'd0, 32'h0);
        send_word(MODE_FINISH, 7'd0, 6'd0, 32'h0);
        send_word(MODE_ENCODE, 7'd5, 6'd0, 32'h0);
        send_word(MODE_ENCODE, 7'd127, 6'd0, 32'h0);
        send_word(MODE_ENCODE, 7'd3, 6'd0, 32'h0);
        send_word(MODE_ENCODE, 7'd0, 6'd0, 32'h0);
        send_word(MODE_ENCODE, 7'd127, 6'd0, 32'h0);
        send_word(MODE_ENCODE, 7'd9, 6'd0, 32'h0);
        send_word(MODE_ENCODE, 7'd10, 6'd0, 32'h0);
        send_word(MODE_UNUSED, 7'd127, 6'd63, 32'hFFFF_FFFF);
        send_word(MODE_ENCODE, 7'd64, 6'd63, 32'hFFFF_FFFF);
        send_word(MODE_FINISH, 7'd127, 6'd63, 32'hFFFF_FFFF);
        send_word(MODE_FINISH, 7'd0, 6'd0, 32'h0);
        stop_sending();
    endtask

    task automatic test_random_stream();
        send_random(150, 1'b0);
        stop_sending();
    endtask

    task automatic test_back_to_back();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        send_random(80, 1'b0);
        stop_sending();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    task automatic test_backpressure();
        hold_req = hold_req + 1;
        send_random(60, 1'b1);
        send_word(MODE_FINISH, 7'd0, 6'd0, 32'h0);
        stop_sending();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_stream();
        test_back_to_back();
        test_backpressure();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_done) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = hold_req;
            end else begin
                i_m_axis_tready <= !(rx_gaps && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word, expected none, actual data %0h user %0h last %0b",
                         $time, o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
            end else begin
                want = expected_bytes.pop_front();
                check_field("out_byte", want.out_byte, o_m_axis_tdata[7:0]);
                check_field("pad_bits", want.pad_bits, o_m_axis_tdata[10:8]);
                check_field("byte_valid", want.byte_valid, o_m_axis_tuser[0]);
                check_field("end_of_stream", want.end_of_stream, o_m_axis_tuser[1]);
                check_field("last", want.last, o_m_axis_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d words still expected", $time, expected_bytes.size());
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
